// ===== rtl/tfd_pkg.sv =====
// shared codes, constants and frame decode for the touch frame decoder
package tfd_pkg;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] KIND_REJECT = 2'd0;
  localparam logic [1:0] KIND_LEVEL  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_MULTI  = 2'd3;

  localparam logic [0:0] REG_WINDOW    = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam logic [15:0] WINDOW_RESET    = 16'd1000;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd4;

  localparam logic [4:0] POS_TYPE     = 5'd7;
  localparam logic [4:0] POS_ENDPOINT = 5'd8;
  localparam logic [4:0] POS_SUBTYPE  = 5'd13;
  localparam logic [4:0] POS_LENGTH   = 5'd16;
  localparam logic [4:0] POS_OFF      = 5'd17;
  localparam logic [4:0] POS_VALUE    = 5'd20;
  localparam logic [4:0] POS_CLOSE    = 5'd21;
  localparam logic [4:0] POS_MAX      = 5'd31;

  localparam logic [7:0] EP1_CODE = 8'h33;
  localparam logic [7:0] EP2_CODE = 8'h34;
  localparam logic [7:0] EP3_CODE = 8'h35;

  localparam logic [7:0] TYPE_LEVEL = 8'h0D;
  localparam logic [7:0] TYPE_OFF   = 8'h0A;
  localparam logic [7:0] TYPE_CLOSE = 8'h0E;

  localparam logic [7:0] SUB_STOP   = 8'h01;
  localparam logic [7:0] SUB_PLAIN  = 8'h02;
  localparam logic [7:0] SUB_CODED  = 8'h03;

  localparam logic [7:0] STOP_VALUE  = 8'h70;
  localparam logic [7:0] CLOSE_VALUE = 8'h65;
  localparam logic [7:0] LEN_LEVEL   = 8'h04;
  localparam logic [7:0] LEN_OFF     = 8'h01;

  localparam logic [6:0] LEVEL_MAX  = 7'd100;
  localparam logic [6:0] CODED_LOW  = 7'd26;
  localparam logic [6:0] CODED_MID  = 7'd52;
  localparam logic [6:0] CODED_HIGH = 7'd77;

  // reciprocal of ten for 8 bit values: (v * 205) >> 11
  localparam logic [15:0] RECIP_TEN = 16'd205;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] level;
  } dec_t;

  function automatic logic [1:0] endpoint_of(input logic [7:0] code);
    logic [1:0] ep;
    ep = 2'd0;
    if (code == EP1_CODE) ep = 2'd1;
    else if (code == EP2_CODE) ep = 2'd2;
    else if (code == EP3_CODE) ep = 2'd3;
    return ep;
  endfunction

  function automatic dec_t decode_frame(input logic [7:0] typ, input logic [7:0] sub,
                                        input logic [7:0] len, input logic [7:0] off,
                                        input logic [7:0] val, input logic [7:0] cls);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  tens_x10;
    logic [3:0]  units;
    logic [6:0]  base;
    logic        base_ok;
    logic [6:0]  sum;
    dec_t        r;
    prod     = {8'd0, val} * RECIP_TEN;
    tens     = prod[15:11];
    tens_x10 = 8'({3'd0, tens} * 8'd10);
    units    = 4'(val - tens_x10);
    base_ok  = 1'b1;
    case (units)
      4'd0: base = 7'd0;
      4'd4: base = CODED_LOW;
      4'd8: base = CODED_MID;
      4'd2: base = CODED_HIGH;
      default: begin
        base    = 7'd0;
        base_ok = 1'b0;
      end
    endcase
    sum = base + {2'd0, tens};
    r.kind  = KIND_REJECT;
    r.level = 7'd0;
    if (typ == TYPE_LEVEL) begin
      if (len == LEN_LEVEL) begin
        if (sub == SUB_STOP) begin
          if (val == STOP_VALUE) r.kind = KIND_STOP;
        end else if (sub == SUB_PLAIN) begin
          r.kind  = KIND_LEVEL;
          r.level = (val > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : val[6:0];
        end else if (sub == SUB_CODED) begin
          if (base_ok) begin
            r.kind  = KIND_LEVEL;
            r.level = (sum > LEVEL_MAX) ? LEVEL_MAX : sum;
          end
        end
      end
    end else if (typ == TYPE_OFF) begin
      if (len == LEN_OFF && off == 8'd0) r.kind = KIND_LEVEL;
    end else if (typ == TYPE_CLOSE) begin
      if (cls == CLOSE_VALUE) r.kind = KIND_LEVEL;
    end
    return r;
  endfunction

endpackage

// ===== rtl/touch_frame_decoder_multipress.sv =====
// touch panel frame decoder with multi-press detection
// a frame end, or an expiring tick that reports a multi-press, shows its result in the cycle after the beat is taken
// throughput: one input beat per cycle; input stalls only while a result waits unread
// the output register is the only stage; state and decode sit in front of it
// reset: synchronous active-low rst_n clears all captures, counters and the window,
// and loads the press window with 1000 ticks and the threshold with 4
module touch_frame_decoder_multipress (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] endpoint, [8:2] level, [10:9] pressed_button
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] window_ticks_r;
  logic [7:0]  threshold_r;

  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  type_cap_r, ep_cap_r, sub_cap_r, len_cap_r, off_cap_r, val_cap_r, cls_cap_r;
  logic [1:0]  last_button_r, last_button_nxt;
  logic [7:0]  press_count_r, press_count_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [15:0] window_left_r, window_left_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_ep_r, out_btn_r;
  logic [6:0]  out_level_r;

  logic        in_acc;
  logic [1:0]  cmd;
  logic [1:0]  ep;
  tfd_pkg::dec_t dec;
  logic        frame_ok;
  logic        res_valid;
  logic [1:0]  res_kind, res_ep, res_btn;
  logic [6:0]  res_level;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = in_tuser;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_btn_r, out_level_r, out_ep_r};

  assign ep  = tfd_pkg::endpoint_of(ep_cap_r);
  assign dec = tfd_pkg::decode_frame(type_cap_r, sub_cap_r, len_cap_r, off_cap_r,
                                     val_cap_r, cls_cap_r);
  assign frame_ok = (ep != 2'd0) && (dec.kind != tfd_pkg::KIND_REJECT);

  always_comb begin
    byte_index_nxt  = byte_index_r;
    last_button_nxt = last_button_r;
    press_count_nxt = press_count_r;
    pending_nxt     = pending_r;
    window_left_nxt = window_left_r;
    res_valid       = 1'b0;
    res_kind        = tfd_pkg::KIND_REJECT;
    res_ep          = 2'd0;
    res_level       = 7'd0;
    res_btn         = 2'd0;
    case (cmd)
      tfd_pkg::CMD_BYTE: begin
        if (byte_index_r != tfd_pkg::POS_MAX) byte_index_nxt = byte_index_r + 5'd1;
      end
      tfd_pkg::CMD_END: begin
        byte_index_nxt = 5'd0;
        res_valid      = 1'b1;
        if (frame_ok) begin
          res_kind  = dec.kind;
          res_ep    = ep;
          res_level = dec.level;
          if (last_button_r == ep) begin
            if (press_count_r != 8'hFF) press_count_nxt = press_count_r + 8'd1;
          end else begin
            last_button_nxt = ep;
            press_count_nxt = 8'd1;
          end
          pending_nxt     = ep;
          window_left_nxt = (window_ticks_r == 16'd0) ? 16'd1 : window_ticks_r;
        end
      end
      tfd_pkg::CMD_TICK: begin
        if (window_left_r != 16'd0) begin
          window_left_nxt = window_left_r - 16'd1;
          if (window_left_r == 16'd1) begin
            pending_nxt     = 2'd0;
            press_count_nxt = 8'd0;
            if (pending_r != 2'd0 && press_count_r >= threshold_r) begin
              res_valid = 1'b1;
              res_kind  = tfd_pkg::KIND_MULTI;
              res_btn   = pending_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= tfd_pkg::WINDOW_RESET;
      threshold_r    <= tfd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tfd_pkg::REG_WINDOW:    window_ticks_r <= cfg_data;
        tfd_pkg::REG_THRESHOLD: threshold_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= 5'd0;
      type_cap_r    <= 8'd0;
      ep_cap_r      <= 8'd0;
      sub_cap_r     <= 8'd0;
      len_cap_r     <= 8'd0;
      off_cap_r     <= 8'd0;
      val_cap_r     <= 8'd0;
      cls_cap_r     <= 8'd0;
      last_button_r <= 2'd0;
      press_count_r <= 8'd0;
      pending_r     <= 2'd0;
      window_left_r <= 16'd0;
    end else if (in_acc) begin
      byte_index_r  <= byte_index_nxt;
      last_button_r <= last_button_nxt;
      press_count_r <= press_count_nxt;
      pending_r     <= pending_nxt;
      window_left_r <= window_left_nxt;
      if (cmd == tfd_pkg::CMD_BYTE) begin
        case (byte_index_r)
          tfd_pkg::POS_TYPE:     type_cap_r <= in_tdata;
          tfd_pkg::POS_ENDPOINT: ep_cap_r   <= in_tdata;
          tfd_pkg::POS_SUBTYPE:  sub_cap_r  <= in_tdata;
          tfd_pkg::POS_LENGTH:   len_cap_r  <= in_tdata;
          tfd_pkg::POS_OFF:      off_cap_r  <= in_tdata;
          tfd_pkg::POS_VALUE:    val_cap_r  <= in_tdata;
          tfd_pkg::POS_CLOSE:    cls_cap_r  <= in_tdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind_r  <= res_kind;
      out_ep_r    <= res_ep;
      out_level_r <= res_level;
      out_btn_r   <= res_btn;
    end
  end

endmodule
